// File: sv/icv_pkg.sv
// shared types, constants and the crc fold function for the image crc-32 verifier
package icv_pkg;

    localparam int unsigned CRC_W      = 32;
    localparam int unsigned SIZE_W     = 21;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFFFFFF;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_MATCH    = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_BAD_SIZE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXPECTED_CRC = 1'd0,
        REG_IMAGE_SIZE   = 1'd1
    } cfg_reg_t;

    // reflected crc-32 update, one byte, lsb first
    function automatic logic [CRC_W-1:0] fold_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : '0);
        end
        return crc;
    endfunction

endpackage

// File: sv/icv_byte_if.sv
// byte stream channel carrying image bytes
interface icv_byte_if;
    logic                          valid;
    logic                          ready;
    logic [icv_pkg::BYTE_W-1:0]    data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// File: sv/icv_result_if.sv
// result channel carrying check status and final crc
interface icv_result_if;
    logic                          valid;
    logic                          ready;
    logic [icv_pkg::STATUS_W-1:0]  status;
    logic [icv_pkg::CRC_W-1:0]     computed_crc;

    modport source (output valid, output status, output computed_crc, input ready);
    modport sink   (input valid, input status, input computed_crc, output ready);
endinterface

// File: sv/icv_cfg_if.sv
// configuration write channel: register index and write data
interface icv_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [icv_pkg::CFG_IDX_W-1:0]  index;
    logic [icv_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/image_crc32_verifier_top.sv
// Image CRC-32 verifier: folds one image byte per transaction into a reflected
// CRC-32 (preset all ones) and, once image_size bytes have been seen, emits one
// result with the inverted CRC and a match or mismatch status, then restarts.
// A byte is accepted every cycle at full rate while the result register is free or
// being drained; the byte that completes the image passes through the input register,
// the unrolled 8-bit CRC fold and the result register, which holds the result. If image_size is zero
// or above MAX_IMAGE_BYTES each byte yields a bad-size result and is dropped.
// Configuration writes are always accepted and do not clear the running CRC.
module image_crc32_verifier_top #(
    parameter int unsigned MAX_IMAGE_BYTES = 1048576
) (
    input  logic              clk,
    input  logic              rst_n,
    icv_byte_if.sink          byte_in,
    icv_result_if.source      result_out,
    icv_cfg_if.sink           cfg
);

    localparam logic [31:0] MAX_BYTES_W = 32'(MAX_IMAGE_BYTES);

    // configuration registers
    logic [icv_pkg::CRC_W-1:0]  expected_crc_reg;
    logic [icv_pkg::SIZE_W-1:0] image_size_reg;

    // input stage
    logic                        in_valid_reg;
    logic [icv_pkg::BYTE_W-1:0]  byte_reg;

    // running state
    logic [icv_pkg::CRC_W-1:0]   crc_reg, crc_next;
    logic [icv_pkg::SIZE_W-1:0]  count_reg, count_next;

    // result stage
    logic                        out_valid_reg, out_valid_next;
    icv_pkg::status_t            status_reg, status_next;
    logic [icv_pkg::CRC_W-1:0]   result_crc_reg, result_crc_next;

    logic                        advance;
    logic                        bad_size;
    logic [icv_pkg::CRC_W-1:0]   folded;
    logic [icv_pkg::CRC_W-1:0]   final_crc;
    logic [icv_pkg::SIZE_W-1:0]  count_inc;

    // configuration port
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_crc_reg <= '0;
            image_size_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (icv_pkg::cfg_reg_t'(cfg.index))
                icv_pkg::REG_EXPECTED_CRC: expected_crc_reg <= cfg.data;
                icv_pkg::REG_IMAGE_SIZE:   image_size_reg   <= cfg.data[icv_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: stage moves when the result register is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign byte_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            in_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.ready && byte_in.valid)
        begin
            byte_reg <= byte_in.data_byte;
        end
    end

    // crc fold, byte count and end-of-image check
    assign bad_size  = (image_size_reg == '0)
                    || ({{(32-icv_pkg::SIZE_W){1'b0}}, image_size_reg} > MAX_BYTES_W);
    assign folded    = icv_pkg::fold_byte(crc_reg, byte_reg);
    assign final_crc = ~folded;
    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        crc_next        = crc_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !result_out.ready;
        status_next     = status_reg;
        result_crc_next = result_crc_reg;
        if (advance)
        begin
            if (bad_size)
            begin
                out_valid_next  = 1'b1;
                status_next     = icv_pkg::STATUS_BAD_SIZE;
                result_crc_next = '0;
            end
            else if (count_inc >= image_size_reg)
            begin
                out_valid_next  = 1'b1;
                status_next     = (final_crc == expected_crc_reg) ?
                                  icv_pkg::STATUS_MATCH : icv_pkg::STATUS_MISMATCH;
                result_crc_next = final_crc;
                crc_next        = icv_pkg::CRC_PRESET;
                count_next      = '0;
            end
            else
            begin
                crc_next   = folded;
                count_next = count_inc;
            end
        end
    end

    // state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= icv_pkg::CRC_PRESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        result_crc_reg <= result_crc_next;
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.status       = status_reg;
    assign result_out.computed_crc = result_crc_reg;

endmodule

// File: sim/tb_image_crc32_verifier_top.sv
// testbench for image_crc32_verifier_top: queued byte driver, result monitor, crc predictor
module tb_image_crc32_verifier_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_BYTES      = 1048576;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned STAGE_BYTES    = 500;
    localparam logic [icv_pkg::CRC_W-1:0] REFL_POLY = 32'hEDB88320;

    typedef struct {
        logic [icv_pkg::BYTE_W-1:0] value;
        bit                         hold;
    } image_byte_t;

    typedef struct packed {
        icv_pkg::status_t          status;
        logic [icv_pkg::CRC_W-1:0] crc;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;

    icv_byte_if   byte_if();
    icv_result_if result_if();
    icv_cfg_if    cfg_if();

    image_crc32_verifier_top #(
        .MAX_IMAGE_BYTES (MAX_BYTES)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_if),
        .result_out (result_if),
        .cfg        (cfg_if)
    );

    // bytes waiting to be sent and verdicts waiting to arrive
    image_byte_t image_bytes_q[$];
    verdict_t    verdict_q[$];

    // predictor copy of the registers and the image state
    logic [icv_pkg::CRC_W-1:0]  expected_crc_reg = '0;
    logic [icv_pkg::SIZE_W-1:0] image_size_reg   = '0;
    logic [icv_pkg::CRC_W-1:0]  crc_acc          = '1;
    logic [icv_pkg::SIZE_W-1:0] bytes_seen_acc   = '0;

    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned check_failures = 0;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #1_600_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // reflected crc-32, one data bit per step, lsb first
    function automatic logic [icv_pkg::CRC_W-1:0] crc32_shift_byte(
        input logic [icv_pkg::CRC_W-1:0]  crc,
        input logic [icv_pkg::BYTE_W-1:0] b
    );
        logic [icv_pkg::CRC_W-1:0] c;
        logic                      fb;
        c = crc;
        for (int i = 0; i < icv_pkg::BYTE_W; i++)
        begin
            fb = c[0] ^ b[i];
            c  = {1'b0, c[icv_pkg::CRC_W-1:1]} ^ (fb ? REFL_POLY : '0);
        end
        return c;
    endfunction

    // fold one accepted byte and record the verdict it causes, if any
    task automatic absorb_image_byte(input logic [icv_pkg::BYTE_W-1:0] b);
        verdict_t v;
        if (image_size_reg == '0 || image_size_reg > MAX_BYTES)
        begin
            v.status = icv_pkg::STATUS_BAD_SIZE;
            v.crc    = '0;
            verdict_q.push_back(v);
        end
        else
        begin
            crc_acc        = crc32_shift_byte(crc_acc, b);
            bytes_seen_acc = bytes_seen_acc + 1'b1;
            if (bytes_seen_acc >= image_size_reg)
            begin
                v.crc    = ~crc_acc;
                v.status = (v.crc == expected_crc_reg) ?
                           icv_pkg::STATUS_MATCH : icv_pkg::STATUS_MISMATCH;
                verdict_q.push_back(v);
                crc_acc        = '1;
                bytes_seen_acc = '0;
            end
        end
    endtask

    // byte driver: holds valid until accepted, random gaps, optional drain before a byte
    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        image_byte_t nxt;
        if (!rst_n)
        begin
            byte_if.valid     <= 1'b0;
            byte_if.data_byte <= '0;
        end
        else
        begin
            if (byte_if.valid && byte_if.ready)
                absorb_image_byte(byte_if.data_byte);
            if (!byte_if.valid || byte_if.ready)
            begin
                if (image_bytes_q.size() != 0
                    && !(image_bytes_q[0].hold && verdict_q.size() != 0)
                    && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    nxt = image_bytes_q.pop_front();
                    byte_if.valid     <= 1'b1;
                    byte_if.data_byte <= nxt.value;
                end
                else
                begin
                    byte_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compare each transaction with the oldest verdict
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        verdict_t want;
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual status %0d crc %h",
                             $time, result_if.status, result_if.computed_crc);
                    check_failures++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (want.status !== result_if.status)
                    begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, result_if.status);
                        check_failures++;
                    end
                    if (want.crc !== result_if.computed_crc)
                    begin
                        $display("%0t: computed_crc mismatch, expected %h actual %h",
                                 $time, want.crc, result_if.computed_crc);
                        check_failures++;
                    end
                end
            end
            result_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    function automatic void queue_byte(input logic [icv_pkg::BYTE_W-1:0] value, input bit hold);
        image_byte_t item;
        item.value = value;
        item.hold  = hold;
        image_bytes_q.push_back(item);
    endfunction

    // register write transaction, predictor follows at acceptance
    task automatic write_reg(input icv_pkg::cfg_reg_t idx,
                             input logic [icv_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        if (idx == icv_pkg::REG_EXPECTED_CRC)
            expected_crc_reg = value;
        else
            image_size_reg = value[icv_pkg::SIZE_W-1:0];
        cfg_if.valid <= 1'b0;
    endtask

    // wait for all bytes sent and all verdicts in, then let the pipeline settle
    task automatic wait_drained();
        do @(negedge clk);
        while (image_bytes_q.size() != 0 || byte_if.valid || verdict_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [icv_pkg::CFG_DATA_W-1:0] pick_bad_size();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return MAX_BYTES + 1;
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(MAX_BYTES + 1, 21'h1F_FFFF);
        endcase
    endfunction

    // one random phase: well-formed images mostly, bad sizes and cut-short images now and then
    task automatic random_phase(output int unsigned sent);
        int unsigned                         kind;
        int unsigned                         img_len;
        int unsigned                         n_images;
        int unsigned                         k;
        bit                                  hold;
        bit                                  copy;
        logic [icv_pkg::CRC_W-1:0]           want_crc;
        logic [icv_pkg::CFG_DATA_W-1:0]      size_val;
        logic [icv_pkg::BYTE_W-1:0]          pattern[$];
        sent = 0;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            // bad size: every byte gives its own verdict
            write_reg(icv_pkg::REG_IMAGE_SIZE, pick_bad_size());
            if ($urandom_range(0, 1))
                write_reg(icv_pkg::REG_EXPECTED_CRC, $urandom);
            @(negedge clk);
            n_images = $urandom_range(1, 6);
            repeat (n_images) queue_byte(8'($urandom_range(0, 255)), 1'b0);
            sent = n_images;
        end
        else if (kind < 18)
        begin
            // partial image, maybe a bad-size gap, then size lowered to at most the count
            k = $urandom_range(1, 20);
            write_reg(icv_pkg::REG_EXPECTED_CRC, $urandom);
            size_val = $urandom_range(0, 1) ? MAX_BYTES : $urandom_range(k + 1, 4096);
            write_reg(icv_pkg::REG_IMAGE_SIZE, size_val);
            @(negedge clk);
            repeat (k) queue_byte(8'($urandom_range(0, 255)), 1'b0);
            wait_drained();
            if ($urandom_range(0, 1))
            begin
                write_reg(icv_pkg::REG_IMAGE_SIZE, pick_bad_size());
                @(negedge clk);
                repeat (2) queue_byte(8'($urandom_range(0, 255)), 1'b0);
                wait_drained();
                sent += 2;
            end
            write_reg(icv_pkg::REG_IMAGE_SIZE, $urandom_range(1, k));
            @(negedge clk);
            queue_byte(8'($urandom_range(0, 255)), 1'b0);
            sent += k + 1;
        end
        else
        begin
            // back-to-back images of one size, some equal to the reference pattern
            img_len = ($urandom_range(0, 4) == 0) ?
                      $urandom_range(13, 64) : $urandom_range(1, 12);
            repeat (img_len) pattern.push_back(8'($urandom_range(0, 255)));
            case ($urandom_range(0, 3))
                0, 1:
                begin
                    want_crc = '1;
                    foreach (pattern[i]) want_crc = crc32_shift_byte(want_crc, pattern[i]);
                    want_crc = ~want_crc;
                end
                2: want_crc = $urandom;
                default: want_crc = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            endcase
            if ($urandom_range(0, 1))
            begin
                write_reg(icv_pkg::REG_IMAGE_SIZE, img_len);
                write_reg(icv_pkg::REG_EXPECTED_CRC, want_crc);
            end
            else
            begin
                write_reg(icv_pkg::REG_EXPECTED_CRC, want_crc);
                write_reg(icv_pkg::REG_IMAGE_SIZE, img_len);
            end
            @(negedge clk);
            n_images = $urandom_range(1, 5);
            repeat (n_images)
            begin
                hold = ($urandom_range(0, 7) == 0);
                copy = ($urandom_range(0, 1) == 1);
                foreach (pattern[i])
                    queue_byte(copy ? pattern[i] : 8'($urandom_range(0, 255)), hold && i == 0);
                sent += img_len;
            end
        end
        wait_drained();
    endtask

    // stimulus: reset, directed cases, then three idling stages of random phases
    initial
    begin : stimulus
        int unsigned src_pct_by_stage[3];
        int unsigned snk_pct_by_stage[3];
        int unsigned stage_bytes;
        int unsigned n;
        src_pct_by_stage = '{7, 59, 0};
        snk_pct_by_stage = '{59, 7, 0};
        rst_n        <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= icv_pkg::REG_EXPECTED_CRC;
        cfg_if.data  <= '0;
        src_idle_pct = src_pct_by_stage[0];
        snk_idle_pct = snk_pct_by_stage[0];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // size register still zero after reset
        @(negedge clk);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        wait_drained();

        // standard check string "123456789", size written with bits above the field set
        write_reg(icv_pkg::REG_EXPECTED_CRC, 32'hCBF4_3926);
        write_reg(icv_pkg::REG_IMAGE_SIZE, 32'hFFE0_0009);
        @(negedge clk);
        for (int i = 0; i < 9; i++)
            queue_byte(8'(8'h31 + i), 1'b0);
        wait_drained();

        // one-byte images, the second held until the first verdict is in
        write_reg(icv_pkg::REG_EXPECTED_CRC, 32'h0);
        write_reg(icv_pkg::REG_IMAGE_SIZE, 1);
        @(negedge clk);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        wait_drained();

        // sizes just above the maximum and at the field's top
        write_reg(icv_pkg::REG_EXPECTED_CRC, 32'hFFFF_FFFF);
        write_reg(icv_pkg::REG_IMAGE_SIZE, MAX_BYTES + 1);
        @(negedge clk);
        queue_byte(8'hA5, 1'b0);
        wait_drained();
        write_reg(icv_pkg::REG_IMAGE_SIZE, 32'hFFFF_FFFF);
        @(negedge clk);
        queue_byte(8'h5A, 1'b0);
        wait_drained();

        // largest size, then lowered below the bytes already seen
        write_reg(icv_pkg::REG_IMAGE_SIZE, MAX_BYTES);
        @(negedge clk);
        repeat (6) queue_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_drained();
        write_reg(icv_pkg::REG_IMAGE_SIZE, 3);
        @(negedge clk);
        queue_byte(8'h80, 1'b0);
        wait_drained();

        for (int stage = 0; stage < 3; stage++)
        begin
            @(negedge clk);
            src_idle_pct = src_pct_by_stage[stage];
            snk_idle_pct = snk_pct_by_stage[stage];
            stage_bytes  = 0;
            while (stage_bytes < STAGE_BYTES)
            begin
                random_phase(n);
                stage_bytes += n;
            end
        end

        wait_drained();
        if (check_failures == 0 && verdict_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
